[hw/rtl/hsir_pkg.sv]
package hsir_pkg;

   localparam int unsigned AddrWidth      = 7;
   localparam int unsigned WaitWidth      = 16;
   localparam int unsigned TimeoutWidth   = 8;
   localparam int unsigned CsrIndexWidth  = 2;
   localparam int unsigned CsrDataWidth   = 16;
   localparam int unsigned WordWidth      = 16;
   localparam int unsigned TempCentiWidth = 15;
   localparam int unsigned HumCentiWidth  = 14;

   localparam logic [AddrWidth-1:0]    DeviceAddressReset = 7'd68;
   localparam logic [WaitWidth-1:0]    ConversionWaitReset = 16'd50000;
   localparam logic [TimeoutWidth-1:0] AckTimeoutReset    = 8'd200;

   localparam logic [7:0] CmdMeasureHigh = 8'h2C;
   localparam logic [7:0] CmdMeasureLow  = 8'h06;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEVICE_ADDRESS   = 2'd0,
      CSR_CONVERSION_WAIT  = 2'd1,
      CSR_ACK_TIMEOUT      = 2'd2
   } csr_index_type;

   typedef enum logic [15:0] {
      PH_IDLE   = 16'h0001,
      PH_START1 = 16'h0002,
      PH_ADDRW  = 16'h0004,
      PH_ACK1   = 16'h0008,
      PH_CMD1   = 16'h0010,
      PH_ACK2   = 16'h0020,
      PH_CMD2   = 16'h0040,
      PH_ACK3   = 16'h0080,
      PH_STOP1  = 16'h0100,
      PH_WAIT   = 16'h0200,
      PH_START2 = 16'h0400,
      PH_ADDRR  = 16'h0800,
      PH_ACKR   = 16'h1000,
      PH_RECV   = 16'h2000,
      PH_MACK   = 16'h4000,
      PH_STOP2  = 16'h8000
   } phase_type;

   typedef struct packed {
      logic [AddrWidth-1:0]    device_address;
      logic [WaitWidth-1:0]    conversion_wait_ticks;
      logic [TimeoutWidth-1:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic scl;
      logic sda_out;
      logic sda_drive_enable;
      logic busy;
      logic done;
      logic ack_error;
   } status_type;

   // True on the receive ticks at which SCL is high and a data bit is sampled.
   function automatic logic is_sample_tick(input logic [4:0] tc);
      logic hit;
      hit = 1'b0;
      for (int i = 1; i <= 8; i++) begin
         if (tc == 5'(3 * i)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

[hw/rtl/humidity_sensor_i2c_reader_core.sv]
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_ready    req_mode, req_sda_in
// rsp_      out        rsp_valid / rsp_ready    pin levels, status, raw and scaled words
// csr_      in         csr_valid / csr_ready    csr_index, csr_data
//
// Each item is one tick of the bus sequencer and yields one registered result item.
// One item is accepted per cycle while no result waits or rsp_ready is high; only the result register sets the pace.
// A result waiting on rsp_ready still lets the next item in when rsp_ready is high.
// Synchronous reset returns to idle with both lines high and driven and the words at zero.
// Configuration writes are always ready and are registered before they take effect.
module humidity_sensor_i2c_reader_core
   import hsir_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic                             req_sda_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_scl,
   output logic                             rsp_sda_out,
   output logic                             rsp_sda_drive_enable,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic                             rsp_ack_error,
   output logic [WordWidth-1:0]             rsp_temperature_raw,
   output logic [WordWidth-1:0]             rsp_humidity_raw,
   output logic signed [TempCentiWidth-1:0] rsp_temperature_centi,
   output logic [HumCentiWidth-1:0]         rsp_humidity_centi,
   output logic                             rsp_in_range,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CsrIndexWidth-1:0]         csr_index,
   input  logic [CsrDataWidth-1:0]          csr_data
);

   cfg_type                          cfg_ff;
   status_type                       status, status_ff;
   logic [WordWidth-1:0]             tword, hword, tword_ff, hword_ff;
   logic signed [TempCentiWidth-1:0] tcenti, tcenti_ff;
   logic [HumCentiWidth-1:0]         hcenti, hcenti_ff;
   logic                             range, range_ff;
   logic                             rsp_valid_ff, rsp_valid_in, accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address        <= DeviceAddressReset;
         cfg_ff.conversion_wait_ticks <= ConversionWaitReset;
         cfg_ff.ack_timeout           <= AckTimeoutReset;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS:  cfg_ff.device_address <= csr_data[AddrWidth-1:0];
            CSR_CONVERSION_WAIT: cfg_ff.conversion_wait_ticks <= csr_data[WaitWidth-1:0];
            CSR_ACK_TIMEOUT:     cfg_ff.ack_timeout <= csr_data[TimeoutWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   hsir_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .step             (accept),
      .mode             (req_mode),
      .sda_in           (req_sda_in),
      .cfg              (cfg_ff),
      .status           (status),
      .temperature_word (tword),
      .humidity_word    (hword)
   );

   hsir_conv u_conv (
      .temperature_word  (tword),
      .humidity_word     (hword),
      .temperature_centi (tcenti),
      .humidity_centi    (hcenti),
      .in_range          (range)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
         tword_ff  <= tword;
         hword_ff  <= hword;
         tcenti_ff <= tcenti;
         hcenti_ff <= hcenti;
         range_ff  <= range;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_scl               = status_ff.scl;
   assign rsp_sda_out           = status_ff.sda_out;
   assign rsp_sda_drive_enable  = status_ff.sda_drive_enable;
   assign rsp_busy_res          = status_ff.busy;
   assign rsp_done_res          = status_ff.done;
   assign rsp_ack_error         = status_ff.ack_error;
   assign rsp_temperature_raw   = tword_ff;
   assign rsp_humidity_raw      = hword_ff;
   assign rsp_temperature_centi = tcenti_ff;
   assign rsp_humidity_centi    = hcenti_ff;
   assign rsp_in_range          = range_ff;

endmodule

[hw/rtl/hsir_seq.sv]
module hsir_seq
   import hsir_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 mode,
   input  logic                 sda_in,
   input  cfg_type              cfg,
   output status_type           status,
   output logic [WordWidth-1:0] temperature_word,
   output logic [WordWidth-1:0] humidity_word
);

   phase_type         phase_ff, phase_in, ph, enter_ph;
   logic [15:0]       tick_ff, tick_in, tc, tc_inc;
   logic [3:0]        bit_ff, bit_in, bc, bc_inc;
   logic [2:0]        byte_ff, byte_in, byc, byc_inc;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        polls_ff, polls_in, polls_dec;
   logic              scl_ff, scl_in, sda_ff, sda_in_pin, drv_ff, drv_in;
   logic [WordWidth-1:0] tword_ff, tword_in, hword_ff, hword_in;
   logic [7:0]        rb0_ff, rb1_ff, rb3_ff, rb4_ff;
   logic              start_req, enter_en, rb_wr, done, err;

   always_comb begin
      start_req  = (phase_ff == PH_IDLE) && mode;
      ph         = start_req ? PH_START1 : phase_ff;
      tc         = start_req ? 16'd0 : tick_ff;
      bc         = start_req ? 4'd0 : bit_ff;
      byc        = start_req ? 3'd0 : byte_ff;
      tc_inc     = tc + 16'd1;
      bc_inc     = bc + 4'd1;
      byc_inc    = byc + 3'd1;
      polls_dec  = polls_ff - 8'd1;
      phase_in   = ph;
      tick_in    = tc;
      bit_in     = bc;
      byte_in    = byc;
      shift_in   = shift_ff;
      polls_in   = polls_ff;
      scl_in     = scl_ff;
      sda_in_pin = sda_ff;
      drv_in     = drv_ff;
      tword_in   = tword_ff;
      hword_in   = hword_ff;
      rb_wr      = 1'b0;
      done       = 1'b0;
      err        = 1'b0;
      enter_en   = 1'b0;
      enter_ph   = PH_IDLE;
      case (ph)
         PH_IDLE: begin
         end
         PH_START1, PH_START2: begin
            drv_in     = 1'b1;
            scl_in     = 1'b1;
            sda_in_pin = (tc < 16'd4);
            tick_in    = tc_inc;
            if (tc_inc >= 16'd8) begin
               enter_en = 1'b1;
               enter_ph = (ph == PH_START1) ? PH_ADDRW : PH_ADDRR;
            end
         end
         PH_ADDRW, PH_CMD1, PH_CMD2, PH_ADDRR: begin
            drv_in     = 1'b1;
            sda_in_pin = shift_ff[3'd7 - bc[2:0]];
            scl_in     = (tc == 16'd2) || (tc == 16'd3);
            tick_in    = tc_inc;
            if (tc_inc >= 16'd6) begin
               tick_in = 16'd0;
               bit_in  = bc_inc;
               if (bc_inc >= 4'd8) begin
                  enter_en = 1'b1;
                  case (ph)
                     PH_ADDRW: enter_ph = PH_ACK1;
                     PH_CMD1:  enter_ph = PH_ACK2;
                     PH_CMD2:  enter_ph = PH_ACK3;
                     default:  enter_ph = PH_ACKR;
                  endcase
               end
            end
         end
         PH_ACK1, PH_ACK2, PH_ACK3, PH_ACKR: begin
            scl_in = 1'b0;
            drv_in = 1'b0;
            case (ph)
               PH_ACK1: enter_ph = PH_CMD1;
               PH_ACK2: enter_ph = PH_CMD2;
               PH_ACK3: enter_ph = PH_STOP1;
               default: enter_ph = PH_RECV;
            endcase
            if (tc < 16'd3) begin
               if (tc < 16'd2) begin
                  drv_in     = 1'b1;
                  sda_in_pin = 1'b1;
               end
               tick_in = tc_inc;
            end else if (tc == 16'd3) begin
               if (!sda_in) begin
                  tick_in = 16'd5;
               end else begin
                  polls_in = polls_dec;
                  if (polls_dec == 8'd0) begin
                     if (ph == PH_ACKR) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                        err      = 1'b1;
                     end else begin
                        enter_en = 1'b1;
                     end
                  end else begin
                     tick_in = 16'd4;
                  end
               end
            end else if (tc == 16'd4) begin
               tick_in = 16'd3;
            end else if (tc == 16'd5) begin
               scl_in  = 1'b1;
               tick_in = 16'd6;
            end else begin
               enter_en = 1'b1;
            end
         end
         PH_STOP1, PH_STOP2: begin
            drv_in     = 1'b1;
            scl_in     = (tc >= 16'd4);
            sda_in_pin = (tc >= 16'd8);
            tick_in    = tc_inc;
            if (tc_inc >= 16'd12) begin
               if (ph == PH_STOP1) begin
                  enter_en = 1'b1;
                  enter_ph = PH_WAIT;
               end else begin
                  tword_in = {rb0_ff, rb1_ff};
                  hword_in = {rb3_ff, rb4_ff};
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            end
         end
         PH_WAIT: begin
            tick_in = tc_inc;
            if (tc_inc >= cfg.conversion_wait_ticks) begin
               enter_en = 1'b1;
               enter_ph = PH_START2;
            end
         end
         PH_RECV: begin
            drv_in = 1'b0;
            if (tc != 16'd0) begin
               if (is_sample_tick(tc[4:0])) begin
                  scl_in   = 1'b1;
                  shift_in = {shift_ff[6:0], sda_in};
               end else begin
                  scl_in = 1'b0;
               end
            end
            tick_in = tc_inc;
            if (tc_inc >= 16'd25) begin
               rb_wr    = 1'b1;
               enter_en = 1'b1;
               enter_ph = PH_MACK;
            end
         end
         PH_MACK: begin
            drv_in = 1'b1;
            if (tc >= 16'd2) begin
               sda_in_pin = (byc >= 3'd5);
            end
            scl_in  = (tc == 16'd4) || (tc == 16'd5);
            tick_in = tc_inc;
            if (tc_inc >= 16'd7) begin
               byte_in  = byc_inc;
               enter_en = 1'b1;
               enter_ph = (byc_inc < 3'd6) ? PH_RECV : PH_STOP2;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (enter_en) begin
         phase_in = enter_ph;
         tick_in  = 16'd0;
         bit_in   = 4'd0;
         case (enter_ph)
            PH_START1: byte_in  = 3'd0;
            PH_ADDRW:  shift_in = {cfg.device_address, 1'b0};
            PH_CMD1:   shift_in = CmdMeasureHigh;
            PH_CMD2:   shift_in = CmdMeasureLow;
            PH_ADDRR:  shift_in = {cfg.device_address, 1'b1};
            PH_ACK1, PH_ACK2, PH_ACK3, PH_ACKR: polls_in = cfg.ack_timeout;
            PH_WAIT: begin
               if (cfg.conversion_wait_ticks == '0) begin
                  phase_in = PH_START2;
               end
            end
            PH_RECV:   shift_in = 8'd0;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         polls_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b1;
         tword_ff <= '0;
         hword_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         polls_ff <= polls_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_pin;
         drv_ff   <= drv_in;
         tword_ff <= tword_in;
         hword_ff <= hword_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && rb_wr) begin
         case (byc)
            3'd0:    rb0_ff <= shift_in;
            3'd1:    rb1_ff <= shift_in;
            3'd3:    rb3_ff <= shift_in;
            3'd4:    rb4_ff <= shift_in;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status.scl              = scl_in;
      status.sda_out          = drv_in & sda_in_pin;
      status.sda_drive_enable = drv_in;
      status.busy             = (ph != PH_IDLE);
      status.done             = done;
      status.ack_error        = err;
   end

   assign temperature_word = tword_in;
   assign humidity_word    = hword_in;

endmodule

[hw/rtl/hsir_conv.sv]
module hsir_conv
   import hsir_pkg::*;
(
   input  logic [WordWidth-1:0]             temperature_word,
   input  logic [WordWidth-1:0]             humidity_word,
   output logic signed [TempCentiWidth-1:0] temperature_centi,
   output logic [HumCentiWidth-1:0]         humidity_centi,
   output logic                             in_range
);

   // Division by 65535 is done as (x + (x >> 16) + 1) >> 16, exact for every x that arises here (all below 2^31).
   logic [31:0] t_x, t_q, h_x, h_q;

   always_comb begin
      t_x = 32'(temperature_word) * 32'd17500 + 32'd32767;
      t_q = t_x + 32'(t_x[31:16]) + 32'd1;
      h_x = 32'(humidity_word) * 32'd10000 + 32'd32767;
      h_q = h_x + 32'(h_x[31:16]) + 32'd1;
      temperature_centi = $signed(t_q[16 +: TempCentiWidth] - 15'd4500);
      humidity_centi    = h_q[16 +: HumCentiWidth];
      in_range          = (temperature_word >= 16'd9363) && (temperature_word <= 16'd63662);
   end

endmodule

[dv/hsir_sequence_checker.sv]
`timescale 1ns / 1ps

module hsir_sequence_checker
   import hsir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_mode,
   input  logic                      req_sda_in,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_scl,
   input  logic                      rsp_sda_out,
   input  logic                      rsp_sda_drive_enable,
   input  logic                      rsp_busy_res,
   input  logic                      rsp_done_res,
   input  logic                      rsp_ack_error,
   input  logic [WordWidth-1:0]      rsp_temperature_raw,
   input  logic [WordWidth-1:0]      rsp_humidity_raw,
   input  logic [TempCentiWidth-1:0] rsp_temperature_centi,
   input  logic [HumCentiWidth-1:0]  rsp_humidity_centi,
   input  logic                      rsp_in_range,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0]   csr_data,
   output int                        failures,
   output int                        outstanding
);

   typedef struct packed {
      logic                      scl;
      logic                      sda_out;
      logic                      drive;
      logic                      busy;
      logic                      done;
      logic                      ack_error;
      logic [WordWidth-1:0]      temp_raw;
      logic [WordWidth-1:0]      hum_raw;
      logic [TempCentiWidth-1:0] temp_centi;
      logic [HumCentiWidth-1:0]  hum_centi;
      logic                      in_range;
   } bus_tick_type;

   bus_tick_type tick_outcomes[$];
   int mismatches = 0;

   logic [AddrWidth-1:0]    cfg_addr;
   logic [WaitWidth-1:0]    cfg_wait;
   logic [TimeoutWidth-1:0] cfg_timeout;

   phase_type   ph;
   logic [15:0] tick_cnt;
   logic [3:0]  bit_cnt;
   logic [2:0]  byte_cnt;
   logic [7:0]  shifter;
   logic [7:0]  rx_bytes [6];
   logic [7:0]  polls_left;
   logic [15:0] temp_word;
   logic [15:0] hum_word;
   logic        line_scl;
   logic        line_sda;
   logic        line_drv;

   initial begin
      failures = 0;
      outstanding = 0;
   end

   task automatic clear_sequencer();
      cfg_addr    = DeviceAddressReset;
      cfg_wait    = ConversionWaitReset;
      cfg_timeout = AckTimeoutReset;
      ph          = PH_IDLE;
      tick_cnt    = '0;
      bit_cnt     = '0;
      byte_cnt    = '0;
      shifter     = '0;
      for (int i = 0; i < 6; i++) begin
         rx_bytes[i] = '0;
      end
      polls_left = '0;
      temp_word  = '0;
      hum_word   = '0;
      line_scl   = 1'b1;
      line_sda   = 1'b1;
      line_drv   = 1'b1;
   endtask

   function automatic phase_type following_phase(input phase_type p);
      return phase_type'(p << 1);
   endfunction

   task automatic enter_phase(input phase_type p);
      ph       = p;
      tick_cnt = '0;
      bit_cnt  = '0;
      case (p)
         PH_START1: byte_cnt = '0;
         PH_ADDRW: shifter = {cfg_addr, 1'b0};
         PH_CMD1: shifter = CmdMeasureHigh;
         PH_CMD2: shifter = CmdMeasureLow;
         PH_ADDRR: shifter = {cfg_addr, 1'b1};
         PH_ACK1, PH_ACK2, PH_ACK3, PH_ACKR: polls_left = cfg_timeout;
         PH_WAIT: begin
            if (cfg_wait == '0) ph = PH_START2;
         end
         PH_RECV: shifter = '0;
         default: ;
      endcase
   endtask

   task automatic drive_bus_tick(input logic sda, output logic done, output logic err);
      logic [15:0] tc;
      tc   = tick_cnt;
      done = 1'b0;
      err  = 1'b0;
      case (ph)
         PH_START1, PH_START2: begin
            line_drv = 1'b1;
            line_scl = 1'b1;
            line_sda = (tc < 4);
            tick_cnt++;
            if (tick_cnt >= 8) enter_phase(following_phase(ph));
         end
         PH_ADDRW, PH_CMD1, PH_CMD2, PH_ADDRR: begin
            line_drv = 1'b1;
            line_sda = shifter[3'd7 - bit_cnt[2:0]];
            line_scl = (tc == 2 || tc == 3);
            tick_cnt++;
            if (tick_cnt >= 6) begin
               tick_cnt = '0;
               bit_cnt++;
               if (bit_cnt >= 8) enter_phase(following_phase(ph));
            end
         end
         PH_ACK1, PH_ACK2, PH_ACK3, PH_ACKR: begin
            line_scl = 1'b0;
            line_drv = 1'b0;
            if (tc < 3) begin
               if (tc < 2) begin
                  line_drv = 1'b1;
                  line_sda = 1'b1;
               end
               tick_cnt++;
            end else if (tc == 3) begin
               if (!sda) begin
                  tick_cnt = 16'd5;
               end else begin
                  polls_left--;
                  if (polls_left == '0) begin
                     if (ph == PH_ACKR) begin
                        ph   = PH_IDLE;
                        done = 1'b1;
                        err  = 1'b1;
                     end else begin
                        enter_phase(following_phase(ph));
                     end
                  end else begin
                     tick_cnt = 16'd4;
                  end
               end
            end else if (tc == 4) begin
               tick_cnt = 16'd3;
            end else if (tc == 5) begin
               line_scl = 1'b1;
               tick_cnt = 16'd6;
            end else begin
               enter_phase(following_phase(ph));
            end
         end
         PH_STOP1, PH_STOP2: begin
            line_drv = 1'b1;
            line_scl = (tc >= 4);
            line_sda = (tc >= 8);
            tick_cnt++;
            if (tick_cnt >= 12) begin
               if (ph == PH_STOP1) begin
                  enter_phase(PH_WAIT);
               end else begin
                  temp_word = {rx_bytes[0], rx_bytes[1]};
                  hum_word  = {rx_bytes[3], rx_bytes[4]};
                  ph        = PH_IDLE;
                  done      = 1'b1;
               end
            end
         end
         PH_WAIT: begin
            tick_cnt++;
            if (tick_cnt >= cfg_wait) enter_phase(PH_START2);
         end
         PH_RECV: begin
            line_drv = 1'b0;
            if (tc != 0) begin
               if (((int'(tc) - 1) % 3) < 2) begin
                  line_scl = 1'b0;
               end else begin
                  line_scl = 1'b1;
                  shifter  = {shifter[6:0], sda};
               end
            end
            tick_cnt++;
            if (tick_cnt >= 25) begin
               if (byte_cnt < 6) rx_bytes[byte_cnt] = shifter;
               enter_phase(PH_MACK);
            end
         end
         PH_MACK: begin
            line_drv = 1'b1;
            if (tc >= 2) line_sda = (byte_cnt >= 5);
            line_scl = (tc == 4 || tc == 5);
            tick_cnt++;
            if (tick_cnt >= 7) begin
               byte_cnt++;
               if (byte_cnt < 6) enter_phase(PH_RECV);
               else enter_phase(PH_STOP2);
            end
         end
         default: ph = PH_IDLE;
      endcase
   endtask

   task automatic step_sequencer(input logic mode, input logic sda, output bus_tick_type r);
      logic done;
      logic err;
      logic busy;
      int   tw;
      int   hw;
      int   centi;
      done = 1'b0;
      err  = 1'b0;
      if (ph == PH_IDLE && mode) enter_phase(PH_START1);
      busy = (ph != PH_IDLE);
      if (busy) drive_bus_tick(sda, done, err);
      tw           = int'(temp_word);
      hw           = int'(hum_word);
      centi        = (17500 * tw + 32767) / 65535 - 4500;
      r.scl        = line_scl;
      r.sda_out    = line_drv ? line_sda : 1'b0;
      r.drive      = line_drv;
      r.busy       = busy;
      r.done       = done;
      r.ack_error  = err;
      r.temp_raw   = temp_word;
      r.hum_raw    = hum_word;
      r.temp_centi = centi[TempCentiWidth-1:0];
      r.hum_centi  = HumCentiWidth'((10000 * hw + 32767) / 65535);
      r.in_range   = (tw >= 9363 && tw <= 63662);
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      bus_tick_type want;
      bus_tick_type got;
      if (reset) begin
         clear_sequencer();
         tick_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS: cfg_addr = csr_data[AddrWidth-1:0];
               CSR_CONVERSION_WAIT: cfg_wait = csr_data[WaitWidth-1:0];
               CSR_ACK_TIMEOUT: cfg_timeout = csr_data[TimeoutWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_scl, rsp_sda_out, rsp_sda_drive_enable, rsp_busy_res,
                    rsp_done_res, rsp_ack_error, rsp_temperature_raw, rsp_humidity_raw,
                    rsp_temperature_centi, rsp_humidity_centi, rsp_in_range};
            if (tick_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t unexpected item: expected none actual %0h", $time, got);
            end else begin
               want = tick_outcomes.pop_front();
               check_field("scl", 16'(want.scl), 16'(got.scl));
               check_field("sda_out", 16'(want.sda_out), 16'(got.sda_out));
               check_field("sda_drive_enable", 16'(want.drive), 16'(got.drive));
               check_field("busy", 16'(want.busy), 16'(got.busy));
               check_field("done", 16'(want.done), 16'(got.done));
               check_field("ack_error", 16'(want.ack_error), 16'(got.ack_error));
               check_field("temperature_raw", want.temp_raw, got.temp_raw);
               check_field("humidity_raw", want.hum_raw, got.hum_raw);
               check_field("temperature_centi", 16'(want.temp_centi), 16'(got.temp_centi));
               check_field("humidity_centi", 16'(want.hum_centi), 16'(got.hum_centi));
               check_field("in_range", 16'(want.in_range), 16'(got.in_range));
            end
         end
         if (req_valid && req_ready) begin
            step_sequencer(req_mode, req_sda_in, want);
            tick_outcomes.push_back(want);
         end
      end
      outstanding <= tick_outcomes.size();
      failures    <= mismatches;
   end

endmodule

[dv/humidity_sensor_i2c_reader_core_tb.sv]
`timescale 1ns / 1ps

module humidity_sensor_i2c_reader_core_tb;
   import hsir_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_mode = 1'b0;
   logic                      req_sda_in = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_scl;
   logic                      rsp_sda_out;
   logic                      rsp_sda_drive_enable;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic                      rsp_ack_error;
   logic [WordWidth-1:0]      rsp_temperature_raw;
   logic [WordWidth-1:0]      rsp_humidity_raw;
   logic [TempCentiWidth-1:0] rsp_temperature_centi;
   logic [HumCentiWidth-1:0]  rsp_humidity_centi;
   logic                      rsp_in_range;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CsrIndexWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0]   csr_data = '0;
   int                        failures;
   int                        outstanding;
   bit                        no_idle = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   humidity_sensor_i2c_reader_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_sda_in            (req_sda_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_scl               (rsp_scl),
      .rsp_sda_out           (rsp_sda_out),
      .rsp_sda_drive_enable  (rsp_sda_drive_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_ack_error         (rsp_ack_error),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_humidity_raw      (rsp_humidity_raw),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_in_range          (rsp_in_range),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   hsir_sequence_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_sda_in            (req_sda_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_scl               (rsp_scl),
      .rsp_sda_out           (rsp_sda_out),
      .rsp_sda_drive_enable  (rsp_sda_drive_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_ack_error         (rsp_ack_error),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_humidity_raw      (rsp_humidity_raw),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_in_range          (rsp_in_range),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .failures              (failures),
      .outstanding           (outstanding)
   );

   task automatic send_tick(input logic mode, input logic sda);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sda_in <= sda;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Starts are requested with start_pct percent, the data line reads low with low_pct percent.
   task automatic run_ticks(input int count, input int start_pct, input int low_pct);
      for (int i = 0; i < count; i++) begin
         send_tick($urandom_range(0, 99) < start_pct, !($urandom_range(0, 99) < low_pct));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #1_000_000;
      $display("FAIL humidity_sensor_i2c_reader_core");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);

      // Reset settings carry the first transaction into its long conversion wait.
      run_ticks(300, 50, 50);
      drain();
      write_csr(CSR_CONVERSION_WAIT, 16'd3);
      run_ticks(320, 20, 50);

      drain();
      write_csr(CSR_DEVICE_ADDRESS, 16'd127);
      write_csr(CSR_ACK_TIMEOUT, 16'd255);
      write_csr(CSR_CONVERSION_WAIT, 16'd0);
      no_idle = 1'b1;
      run_ticks(300, 30, 50);

      drain();
      no_idle = 1'b0;
      write_csr(CSR_DEVICE_ADDRESS, 16'd0);
      write_csr(CSR_ACK_TIMEOUT, 16'd1);
      write_csr(CSR_CONVERSION_WAIT, 16'd1);
      run_ticks(300, 30, 50);

      drain();
      write_csr(CSR_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
      write_csr(CSR_ACK_TIMEOUT, 16'd0);
      write_csr(CSR_CONVERSION_WAIT, 16'($urandom_range(2, 40)));
      run_ticks(200, 30, 60);

      // With the data line held high every poll fails and the read address is refused.
      drain();
      write_csr(CSR_ACK_TIMEOUT, 16'd2);
      write_csr(CSR_CONVERSION_WAIT, 16'd65535);
      run_ticks(250, 40, 0);
      drain();
      write_csr(CSR_CONVERSION_WAIT, 16'd8);
      run_ticks(150, 40, 0);

      drain();
      write_csr(CSR_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
      write_csr(CSR_ACK_TIMEOUT, 16'($urandom_range(1, 255)));
      write_csr(CSR_CONVERSION_WAIT, 16'($urandom_range(0, 20)));
      run_ticks(150, 25, 50);

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("PASS humidity_sensor_i2c_reader_core");
      end else begin
         $display("FAIL humidity_sensor_i2c_reader_core");
      end
      $finish;
   end

endmodule
